// File: sv/pre_pkg.sv
// ----------------------------------------------------------------------------
// Printable run extractor: shared types and constants
// Word formats of both channels and the job word passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package pre_pkg;

  // Input word: one raw data byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_data;
  } in_word_t;

  // Output word: one string byte or one end mark
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       string_end;
    logic       string_discard;
    logic       last_of_item;
  } out_word_t;

  // Work for the back end from one input word, emitted in this order:
  // raw bytes, held code point, new code point, end mark.
  typedef struct packed {
    logic [2:0]      raw_cnt;
    logic [3:0][7:0] raw;       // raw[0] goes out first
    logic            cp0_vld;
    logic [15:0]     cp0;       // held first unit of a wide run
    logic            cp1_vld;
    logic [20:0]     cp1;       // unit or surrogate pair
    logic            end_mark;
    logic            discard;
  } job_t;

  localparam logic [2:0]  ByteRunMin = 3'd4;
  localparam logic [2:0]  WideRunMin = 3'd2;
  localparam logic [7:0]  PrintLo    = 8'd32;
  localparam logic [7:0]  PrintDel   = 8'd127;
  localparam logic [7:0]  PrintHi    = 8'd160;
  localparam logic [15:0] UnitTab    = 16'd9;
  localparam logic [15:0] UnitLf     = 16'd10;
  localparam logic [15:0] UnitCr     = 16'd13;
  localparam logic [15:0] UnitMinTxt = 16'd32;
  localparam logic [5:0]  SurHiTag   = 6'b110110;
  localparam logic [5:0]  SurLoTag   = 6'b110111;

endpackage

`default_nettype wire

// File: sv/printable_run_extractor_core.sv
// ----------------------------------------------------------------------------
// Printable run extractor core
// Extracts printable byte runs or UTF-16LE text runs from a raw byte stream.
// ----------------------------------------------------------------------------
// Feed the data one byte word per cycle and mark the final byte with
// end_of_data; the open run is flushed and the scan state cleared there.
// scan_mode selects byte runs (0: bytes 32..126 or 160..255, kept when at
// least 4 long, passed on raw) or wide runs (1: little-endian 16-bit units
// 9, 10, 13 or >= 32, kept when at least 2 long, passed on as UTF-8). Each
// kept string ends with an end-mark word; a wide string with an unpaired
// surrogate emits no further bytes once spoiled and ends with string_discard
// set. Write scan_mode only between data passes: the write clears the scan
// state.
// Rate: the input side takes one byte per cycle. The back end sends one
// result word per cycle unless the output stalls, so a byte that causes k
// results (up to 7) keeps the back end busy for k words; the job queue between
// the two absorbs such bursts, and input stalls only when the queue is full.
// A byte that causes no result never reaches the back end. Each result passes
// the job queue, the back end's job register and its output register.
// ----------------------------------------------------------------------------
`default_nettype none

module printable_run_extractor_core #(
  parameter int QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  // byte input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pre_pkg::in_word_t  in_word_i,
  // string output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pre_pkg::out_word_t out_word_o
);
  import pre_pkg::*;

  logic  push, q_full, q_vld, q_pop;
  job_t  push_job, q_job;

  // Front: run tracking, classification, at most one job per byte
  pre_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Queue: decouples input flow from output back-pressure
  pre_fifo #(
    .Depth (QueueDepth),
    .Width ($bits(job_t))
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_job),
    .pop_i    (q_pop),
    .rvalid_o (q_vld),
    .rdata_o  (q_job),
    .full_o   (q_full)
  );

  // Back: serializes each job into result words
  pre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_job_i     (q_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

`ifndef SYNTHESIS
  // discard only rides on an end mark
  a_discard_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.string_discard |->
      out_word_o.string_end && !out_word_o.has_byte)
    else $error("discard flag outside an end mark");

  // a result word never is both a byte and an end mark
  a_byte_xor_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.has_byte |-> !out_word_o.string_end)
    else $error("byte word carries an end mark");

  // results of one byte go out without gaps once the first is taken
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_word_o.last_of_item |=> out_valid_o)
    else $error("gap inside the results of one byte");
`endif

endmodule

`default_nettype wire

// File: sv/pre_front.sv
// ----------------------------------------------------------------------------
// Printable run extractor: front end
// Takes one byte per cycle unless the queue is full, tracks the run state and issues at most one job word per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pre_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pre_pkg::in_word_t in_word_i,
  input  logic              q_full_i,
  output logic              push_o,
  output pre_pkg::job_t     job_o
);
  import pre_pkg::*;

  logic            mode_q;
  logic [2:0]      run_len_q, run_len_d;
  logic            phase_q, phase_d;
  logic [7:0]      low_q, low_d;
  logic [15:0]     held_q, held_d;
  logic [9:0]      phs_q, phs_d;   // payload bits of the waiting high surrogate
  logic            hp_q, hp_d;
  logic            inv_q, inv_d;
  logic [2:0][7:0] pend_q, pend_d;

  logic        acc;
  logic [7:0]  c;
  logic        eod;
  logic [15:0] u;
  logic        printable, unit_txt, is_hi, is_lo, hold;
  job_t        job;

  assign acc        = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign c          = in_word_i.in_byte;
  assign eod        = in_word_i.end_of_data;
  assign u          = {c, low_q};
  assign printable  = (c >= PrintLo && c < PrintDel) || c >= PrintHi;
  assign unit_txt   = u == UnitTab || u == UnitLf || u == UnitCr || u >= UnitMinTxt;
  assign is_hi      = u[15:10] == SurHiTag;
  assign is_lo      = u[15:10] == SurLoTag;
  assign hold       = run_len_q == 3'd0;

  always_comb begin
    job       = '0;
    run_len_d = run_len_q;
    phase_d   = phase_q;
    low_d     = low_q;
    held_d    = held_q;
    phs_d     = phs_q;
    hp_d      = hp_q;
    inv_d     = inv_q;
    pend_d    = pend_q;
    if (!mode_q) begin
      if (!printable) begin
        if (run_len_q >= ByteRunMin) job.end_mark = 1'b1;
        run_len_d = '0;
      end else if (run_len_q >= ByteRunMin) begin
        job.raw_cnt = 3'd1;
        job.raw[0]  = c;
      end else if (run_len_q == ByteRunMin - 3'd1) begin
        job.raw_cnt = 3'd4;
        job.raw[0]  = pend_q[0];
        job.raw[1]  = pend_q[1];
        job.raw[2]  = pend_q[2];
        job.raw[3]  = c;
        run_len_d   = ByteRunMin;
      end else begin
        pend_d[run_len_q[1:0]] = c;
        run_len_d              = run_len_q + 3'd1;
      end
      if (eod && run_len_d >= ByteRunMin) job.end_mark = 1'b1;
    end else begin
      if (!phase_q) begin
        if (!eod) begin
          low_d   = c;
          phase_d = 1'b1;
        end
      end else begin
        phase_d = 1'b0;
        if (!unit_txt) begin
          if (run_len_q >= WideRunMin) begin
            job.end_mark = 1'b1;
            job.discard  = inv_q | hp_q;
          end
          run_len_d = '0;
          held_d    = '0;
          phs_d     = '0;
          hp_d      = 1'b0;
          inv_d     = 1'b0;
        end else if (inv_q) begin
          if (run_len_q < WideRunMin) run_len_d = run_len_q + 3'd1;
        end else begin
          if (run_len_q == 3'd0) begin
            run_len_d = 3'd1;
          end else if (run_len_q == 3'd1) begin
            if (!hp_q) begin
              job.cp0_vld = 1'b1;
              job.cp0     = held_q;
            end
            run_len_d = WideRunMin;
          end
          if (is_hi) begin
            if (hp_q) begin
              inv_d = 1'b1;
            end else begin
              phs_d = u[9:0];
              hp_d  = 1'b1;
            end
          end else if (is_lo) begin
            if (!hp_q) begin
              inv_d = 1'b1;
            end else begin
              job.cp1_vld = 1'b1;
              job.cp1     = 21'h10000 + {1'b0, phs_q, u[9:0]};
              hp_d        = 1'b0;
            end
          end else begin
            if (hp_q) begin
              inv_d = 1'b1;
            end else if (hold) begin
              held_d = u;
            end else begin
              job.cp1_vld = 1'b1;
              job.cp1     = {5'd0, u};
            end
          end
        end
      end
      // flush at end of data; an end mark from above already zeroed the run
      if (eod && run_len_d >= WideRunMin) begin
        job.end_mark = 1'b1;
        job.discard  = inv_d | hp_d;
      end
    end
    if (eod) begin
      run_len_d = '0;
      phase_d   = 1'b0;
      low_d     = '0;
      held_d    = '0;
      phs_d     = '0;
      hp_d      = 1'b0;
      inv_d     = 1'b0;
    end
  end

  assign job_o  = job;
  assign push_o = acc && (job.raw_cnt != 3'd0 || job.cp0_vld || job.cp1_vld || job.end_mark);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      run_len_q <= '0;
      phase_q   <= 1'b0;
      low_q     <= '0;
      held_q    <= '0;
      phs_q     <= '0;
      hp_q      <= 1'b0;
      inv_q     <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q    <= cfg_wdata_i;
      run_len_q <= '0;
      phase_q   <= 1'b0;
      low_q     <= '0;
      held_q    <= '0;
      phs_q     <= '0;
      hp_q      <= 1'b0;
      inv_q     <= 1'b0;
    end else if (acc) begin
      run_len_q <= run_len_d;
      phase_q   <= phase_d;
      low_q     <= low_d;
      held_q    <= held_d;
      phs_q     <= phs_d;
      hp_q      <= hp_d;
      inv_q     <= inv_d;
    end
  end

  // short-run byte store: only entries below the run length are read
  always_ff @(posedge clk_i) begin
    if (acc && !cfg_we_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/pre_fifo.sv
// ----------------------------------------------------------------------------
// Printable run extractor: job queue
// Small register queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pre_fifo #(
  parameter int Depth = 4,
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             rvalid_o,
  output logic [Width-1:0] rdata_o,
  output logic             full_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign rvalid_o = cnt_q != '0;
  assign full_o   = cnt_q == FullCnt;
  assign rdata_o  = mem_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && rvalid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= wdata_i;
  end

endmodule

`default_nettype wire

// File: sv/pre_back.sv
// ----------------------------------------------------------------------------
// Printable run extractor: back end
// Walks one job word and sends one result word per cycle unless the output stalls; code points go out UTF-8 encoded.
// ----------------------------------------------------------------------------
`default_nettype none

module pre_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_vld_i,
  input  pre_pkg::job_t      q_job_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pre_pkg::out_word_t out_word_o
);
  import pre_pkg::*;

  typedef enum logic [3:0] {
    SEG_RAW = 4'b0001,
    SEG_CP0 = 4'b0010,
    SEG_CP1 = 4'b0100,
    SEG_END = 4'b1000
  } seg_e;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    if (cp < 21'h80)         utf8_len = 3'd1;
    else if (cp < 21'h800)   utf8_len = 3'd2;
    else if (cp < 21'h10000) utf8_len = 3'd3;
    else                     utf8_len = 3'd4;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
    logic [2:0] len;
    len = utf8_len(cp);
    utf8_byte = cp[7:0];
    case (len)
      3'd2: begin
        utf8_byte = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      end
      3'd3: begin
        case (idx)
          2'd0:    utf8_byte = {4'b1110, cp[15:12]};
          2'd1:    utf8_byte = {2'b10, cp[11:6]};
          default: utf8_byte = {2'b10, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (idx)
          2'd0:    utf8_byte = {5'b11110, cp[20:18]};
          2'd1:    utf8_byte = {2'b10, cp[17:12]};
          2'd2:    utf8_byte = {2'b10, cp[11:6]};
          default: utf8_byte = {2'b10, cp[5:0]};
        endcase
      end
      default: utf8_byte = cp[7:0];
    endcase
  endfunction

  function automatic seg_e first_seg(input job_t j);
    if (j.raw_cnt != 3'd0) first_seg = SEG_RAW;
    else if (j.cp0_vld)    first_seg = SEG_CP0;
    else if (j.cp1_vld)    first_seg = SEG_CP1;
    else                   first_seg = SEG_END;
  endfunction

  job_t       job_q;
  logic       busy_q;
  seg_e       seg_q, seg_nxt;
  logic [1:0] idx_q;
  out_word_t  out_q, res;
  logic       out_vld_q;

  logic [2:0] seg_size;
  logic       later_ne, seg_last, is_last, adv, done;

  always_comb begin
    res       = '0;
    seg_size  = 3'd1;
    later_ne  = 1'b0;
    seg_nxt   = SEG_END;
    case (seg_q)
      SEG_RAW: begin
        res.out_byte = job_q.raw[idx_q];
        res.has_byte = 1'b1;
        seg_size     = job_q.raw_cnt;
        later_ne     = job_q.cp0_vld || job_q.cp1_vld || job_q.end_mark;
        seg_nxt      = job_q.cp0_vld ? SEG_CP0 : (job_q.cp1_vld ? SEG_CP1 : SEG_END);
      end
      SEG_CP0: begin
        res.out_byte = utf8_byte({5'd0, job_q.cp0}, idx_q);
        res.has_byte = 1'b1;
        seg_size     = utf8_len({5'd0, job_q.cp0});
        later_ne     = job_q.cp1_vld || job_q.end_mark;
        seg_nxt      = job_q.cp1_vld ? SEG_CP1 : SEG_END;
      end
      SEG_CP1: begin
        res.out_byte = utf8_byte(job_q.cp1, idx_q);
        res.has_byte = 1'b1;
        seg_size     = utf8_len(job_q.cp1);
        later_ne     = job_q.end_mark;
      end
      SEG_END: begin
        res.string_end     = 1'b1;
        res.string_discard = job_q.discard;
      end
      default: begin
        res = '0;
      end
    endcase
    seg_last         = ({1'b0, idx_q} + 3'd1) == seg_size;
    is_last          = seg_last && !later_ne;
    res.last_of_item = is_last;
  end

  assign adv     = busy_q && (!out_vld_q || !out_stall_i);
  assign done    = adv && is_last;
  assign q_pop_o = q_vld_i && (!busy_q || done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      seg_q     <= SEG_END;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
        seg_q  <= first_seg(q_job_i);
        idx_q  <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (adv) begin
        if (seg_last) begin
          seg_q <= seg_nxt;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) job_q <= q_job_i;
    if (adv)     out_q <= res;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// File: dv/tb_printable_run_extractor_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Printable run extractor core testbench
// Streams byte-mode and wide-mode data passes into the core with random gaps
// and back-pressure, predicts each string byte and end mark in a scan model
// of its own, and compares every output word field by field.
// ----------------------------------------------------------------------------
module tb_printable_run_extractor_core;
  import pre_pkg::*;

  localparam logic ModeByte   = 1'b0;
  localparam logic ModeWide   = 1'b1;
  localparam int   GapPct     = 11;    // sender idles this often, in percent
  localparam int   StallPct   = 11;    // receiver stalls this often, in percent
  localparam int   DrainWait  = 8;     // drain margin once the bench is idle
  localparam int   HoldAfter  = 150;   // input words before the long hold-off
  localparam int   HoldCycles = 80;
  localparam int   WatchLimit = 5000;  // cycles with no handshake at all

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  printable_run_extractor_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Scan model: mirrors the core's run tracking word by word
  // --------------------------------------------------------------------------
  logic       mode_wide;
  logic [7:0] run_head [3];   // first bytes of a byte run still below 4
  logic [2:0] run_len;
  logic       half_phase;     // 1: low byte of a unit is held
  logic [7:0] lo_byte;
  logic [15:0] first_unit;    // first unit of a wide run, sent once run is 2
  logic [15:0] hi_sur;
  logic       hi_wait;
  logic       run_spoiled;

  out_word_t  step_words[$];    // results of the word being predicted
  out_word_t  string_due[$];    // predicted output words not yet seen
  in_word_t   raw_bytes_q[$];   // words waiting for the driver

  int fail_cnt   = 0;
  int words_in   = 0;
  int str_bytes  = 0;
  int str_ends   = 0;
  int str_drops  = 0;

  function automatic void clear_scan_state();
    for (int i = 0; i < 3; i++) run_head[i] = '0;
    run_len     = '0;
    half_phase  = 1'b0;
    lo_byte     = '0;
    first_unit  = '0;
    hi_sur      = '0;
    hi_wait     = 1'b0;
    run_spoiled = 1'b0;
  endfunction

  function automatic void emit(input logic [7:0] b, input logic has, input logic fin,
                               input logic disc);
    out_word_t w;
    w                = '0;
    w.out_byte       = b;
    w.has_byte       = has;
    w.string_end     = fin;
    w.string_discard = disc;
    step_words.insert(step_words.size(), w);
  endfunction

  // UTF-8 encoding of one code point
  function automatic void emit_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], 1'b1, 1'b0, 1'b0);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0);
      emit({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end else if (cp < 21'h10000) begin
      emit({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0);
      emit({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
      emit({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end else begin
      emit({5'b11110, cp[20:18]}, 1'b1, 1'b0, 1'b0);
      emit({2'b10, cp[17:12]}, 1'b1, 1'b0, 1'b0);
      emit({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0);
      emit({2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0);
    end
  endfunction

  function automatic void close_byte_run();
    if (run_len >= ByteRunMin) emit(8'h00, 1'b0, 1'b1, 1'b0);
    run_len = '0;
  endfunction

  function automatic void byte_mode_step(input logic [7:0] c);
    if (!((c >= PrintLo && c < PrintDel) || c >= PrintHi)) begin
      close_byte_run();
    end else if (run_len >= ByteRunMin) begin
      emit(c, 1'b1, 1'b0, 1'b0);
    end else if (run_len == ByteRunMin - 3'd1) begin
      // run just became long enough: flush the held head first
      for (int i = 0; i < 3; i++) emit(run_head[i], 1'b1, 1'b0, 1'b0);
      emit(c, 1'b1, 1'b0, 1'b0);
      run_len = ByteRunMin;
    end else begin
      run_head[run_len[1:0]] = c;
      run_len = run_len + 3'd1;
    end
  endfunction

  function automatic void close_wide_run();
    if (run_len >= WideRunMin) emit(8'h00, 1'b0, 1'b1, run_spoiled | hi_wait);
    run_len     = '0;
    first_unit  = '0;
    hi_sur      = '0;
    hi_wait     = 1'b0;
    run_spoiled = 1'b0;
  endfunction

  // surrogate pairing; with hold set a plain unit is kept back
  function automatic void take_unit(input logic [15:0] u, input logic hold);
    if (u[15:10] == SurHiTag) begin
      if (hi_wait) begin
        run_spoiled = 1'b1;
      end else begin
        hi_sur  = u;
        hi_wait = 1'b1;
      end
    end else if (u[15:10] == SurLoTag) begin
      if (!hi_wait) begin
        run_spoiled = 1'b1;
      end else begin
        hi_wait = 1'b0;
        emit_code_point(21'h10000 + {1'b0, hi_sur[9:0], u[9:0]});
      end
    end else if (hi_wait) begin
      run_spoiled = 1'b1;
    end else if (hold) begin
      first_unit = u;
    end else begin
      emit_code_point({5'b0, u});
    end
  endfunction

  function automatic void wide_mode_unit(input logic [15:0] u);
    if (!(u == UnitTab || u == UnitLf || u == UnitCr || u >= UnitMinTxt)) begin
      close_wide_run();
    end else if (run_spoiled) begin
      if (run_len < WideRunMin) run_len = run_len + 3'd1;
    end else if (run_len == 3'd0) begin
      run_len = 3'd1;
      take_unit(u, 1'b1);
    end else begin
      if (run_len == 3'd1) begin
        if (!hi_wait) emit_code_point({5'b0, first_unit});
        run_len = WideRunMin;
      end
      take_unit(u, 1'b0);
    end
  endfunction

  function automatic void predict_scan(input in_word_t w);
    out_word_t tail;
    step_words.delete();
    if (mode_wide == ModeByte) begin
      byte_mode_step(w.in_byte);
      if (w.end_of_data) close_byte_run();
    end else begin
      if (!half_phase) begin
        // a final byte at an even offset has no partner and is dropped
        if (!w.end_of_data) begin
          lo_byte    = w.in_byte;
          half_phase = 1'b1;
        end
      end else begin
        half_phase = 1'b0;
        wide_mode_unit({w.in_byte, lo_byte});
      end
      if (w.end_of_data) close_wide_run();
    end
    if (w.end_of_data) clear_scan_state();
    if (step_words.size() != 0) begin
      tail              = step_words.pop_back();
      tail.last_of_item = 1'b1;
      step_words.insert(step_words.size(), tail);
    end
    foreach (step_words[i]) string_due.insert(string_due.size(), step_words[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic void check_string_word(input out_word_t got);
    out_word_t want;
    if (string_due.size() == 0) begin
      $error("output word %h with nothing expected", got);
      fail_cnt++;
    end else begin
      want = string_due.pop_front();
      check_field("out_byte", want.out_byte, got.out_byte);
      check_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
      check_field("string_end", 8'(want.string_end), 8'(got.string_end));
      check_field("string_discard", 8'(want.string_discard), 8'(got.string_discard));
      check_field("last_of_item", 8'(want.last_of_item), 8'(got.last_of_item));
    end
    if (got.has_byte) str_bytes++;
    if (got.string_end) str_ends++;
    if (got.string_end && got.string_discard) str_drops++;
  endfunction

  // --------------------------------------------------------------------------
  // Driver, receiver, monitor, watchdog
  // --------------------------------------------------------------------------
  logic no_gaps    = 1'b0;   // set for one pass: both sides run flat out
  logic in_taken   = 1'b0;   // word on the input was taken at the last edge
  logic hold_done  = 1'b0;
  int   hold_left  = 0;
  int   idle_count = 0;

  // New word only once the current one is gone; valid ignores stall.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (raw_bytes_q.size() != 0 && (no_gaps || $urandom_range(99) >= GapPct)) begin
        in_word_i  <= raw_bytes_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Random stalls, plus one long hold-off so the job queue fills and the
  // core has to stall its input.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && words_in >= HoldAfter) begin
      out_stall_i <= 1'b1;
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
    end else begin
      out_stall_i <= !no_gaps && ($urandom_range(99) < StallPct);
    end
  end

  // Everything sampled here sees pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (cfg_we_i) begin
        mode_wide = cfg_wdata_i;
        clear_scan_state();
      end
      if (in_valid_i && !in_stall_o) begin
        words_in++;
        predict_scan(in_word_i);
      end
      if (out_valid_o && !out_stall_i) check_string_word(out_word_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) ||
        (out_valid_o && !out_stall_i)) begin
      idle_count <= 0;
    end else if (idle_count >= WatchLimit) begin
      $display("printable_run_extractor_core: mismatch");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic tx_phase = 1'b0;   // byte offset parity of the data queued so far

  function automatic void queue_byte(input logic [7:0] b, input logic eod);
    in_word_t w;
    w.in_byte     = b;
    w.end_of_data = eod;
    raw_bytes_q.insert(raw_bytes_q.size(), w);
    tx_phase = eod ? 1'b0 : ~tx_phase;
  endfunction

  function automatic void queue_unit(input logic [15:0] u, input logic eod);
    queue_byte(u[7:0], 1'b0);
    queue_byte(u[15:8], eod);
  endfunction

  function automatic logic [7:0] rand_printable();
    if ($urandom_range(2) == 0) return 8'($urandom_range(255, PrintHi));
    return 8'($urandom_range(PrintDel - 8'd1, PrintLo));
  endfunction

  function automatic logic [7:0] rand_stop_byte();
    if ($urandom_range(1) == 0) return 8'($urandom_range(PrintLo - 8'd1));
    return 8'($urandom_range(PrintHi - 8'd1, PrintDel));
  endfunction

  function automatic logic [15:0] rand_text_unit();
    int          k;
    logic [15:0] u;
    k = $urandom_range(9);
    if (k < 5) begin
      u = 16'($urandom_range(126, UnitMinTxt));
    end else if (k == 5) begin
      case ($urandom_range(2))
        0:       u = UnitTab;
        1:       u = UnitLf;
        default: u = UnitCr;
      endcase
    end else if (k < 8) begin
      u = 16'($urandom_range(16'h7FF, 16'h80));
    end else begin
      do u = 16'($urandom_range(16'hFFFF, 16'h800));
      while (u[15:11] == SurHiTag[5:1]);
    end
    return u;
  endfunction

  function automatic logic [15:0] rand_stop_unit();
    logic [15:0] u;
    do u = 16'($urandom_range(UnitMinTxt - 16'd1));
    while (u == UnitTab || u == UnitLf || u == UnitCr);
    return u;
  endfunction

  // one printable run and its terminator or end of data, or a noise byte
  function automatic void add_byte_run();
    int   len;
    int   i;
    logic eod_on_text;
    if ($urandom_range(99) < 15) begin
      queue_byte(8'($urandom), $urandom_range(19) == 0);
    end else begin
      len         = ($urandom_range(4) == 0) ? $urandom_range(12) : $urandom_range(6);
      eod_on_text = (len != 0) && ($urandom_range(7) == 0);
      for (i = 0; i < len; i++) queue_byte(rand_printable(), eod_on_text && i == len - 1);
      if (!eod_on_text) queue_byte(rand_stop_byte(), $urandom_range(9) == 0);
    end
  endfunction

  // mostly well-formed unit runs with surrogate pairs; some lone halves,
  // odd bytes and raw noise mixed in
  function automatic void add_wide_run();
    int n;
    int k;
    int i;
    k = $urandom_range(99);
    if (k < 8) begin
      queue_unit(16'($urandom), $urandom_range(15) == 0);
    end else if (k < 12) begin
      queue_byte(8'($urandom), $urandom_range(3) == 0);
    end else begin
      if (tx_phase) queue_byte(8'($urandom), 1'b0);
      n = $urandom_range(5);
      for (i = 0; i < n; i++) begin
        k = $urandom_range(19);
        if (k < 14) begin
          queue_unit(rand_text_unit(), 1'b0);
        end else if (k < 18) begin
          queue_unit({SurHiTag, 10'($urandom)}, 1'b0);
          queue_unit({SurLoTag, 10'($urandom)}, 1'b0);
        end else if (k == 18) begin
          queue_unit({SurHiTag, 10'($urandom)}, 1'b0);
        end else begin
          queue_unit({SurLoTag, 10'($urandom)}, 1'b0);
        end
      end
      k = $urandom_range(9);
      if (k == 0) queue_byte(rand_printable(), 1'b1);
      else if (k == 1) queue_unit(rand_text_unit(), 1'b1);
      else queue_unit(rand_stop_unit(), k == 2);
    end
  endfunction

  // Mode writes only while idle; returns at a rising edge so the next fill
  // of the word queue never races the driver.
  task automatic write_scan_mode(input logic mode);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    tx_phase = 1'b0;
  endtask

  task automatic wait_idle();
    while (raw_bytes_q.size() != 0 || in_valid_i || string_due.size() != 0)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    mode_wide = ModeByte;
    clear_scan_state();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Byte pass: short run, a run at the minimum length closed by DEL,
    // and a run closed by end of data.
    write_scan_mode(ModeByte);
    queue_byte(8'h78, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'd32, 1'b0);
    queue_byte(8'd126, 1'b0);
    queue_byte(8'd160, 1'b0);
    queue_byte(8'd255, 1'b0);
    queue_byte(8'd127, 1'b0);
    queue_byte(8'h41, 1'b0);
    queue_byte(8'h42, 1'b0);
    queue_byte(8'h43, 1'b0);
    queue_byte(8'hFF, 1'b1);
    while (raw_bytes_q.size() < 120) add_byte_run();
    wait_idle();

    // Wide pass: 1-, 2-, 3- and 4-byte encodings, a lone low surrogate
    // spoiling a run, and an odd byte at end of data.
    write_scan_mode(ModeWide);
    queue_unit(16'h0041, 1'b0);
    queue_unit(16'h00E9, 1'b0);
    queue_unit(16'h20AC, 1'b0);
    queue_unit(16'hD83D, 1'b0);
    queue_unit(16'hDE00, 1'b0);
    queue_unit(16'h0000, 1'b0);
    queue_unit(16'hDC00, 1'b0);
    queue_unit(UnitCr, 1'b0);
    queue_unit(16'h001F, 1'b0);
    queue_byte(8'h5A, 1'b1);
    while (raw_bytes_q.size() < 160) add_wide_run();
    wait_idle();

    // Second byte pass with no gaps on either side
    write_scan_mode(ModeByte);
    no_gaps <= 1'b1;
    while (raw_bytes_q.size() < 60) add_byte_run();
    wait_idle();
    no_gaps <= 1'b0;

    write_scan_mode(ModeWide);
    while (raw_bytes_q.size() < 75) add_wide_run();
    wait_idle();

    $display("Scanned %0d input words in byte, wide, byte, wide passes;", words_in);
    $display("saw %0d string bytes and %0d string ends, %0d of them discards.",
             str_bytes, str_ends, str_drops);
    if (fail_cnt == 0) begin
      $display("printable_run_extractor_core: match");
    end else begin
      $display("printable_run_extractor_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
sv/pre_pkg.sv
sv/pre_front.sv
sv/pre_fifo.sv
sv/pre_back.sv
sv/printable_run_extractor_core.sv
dv/tb_printable_run_extractor_core.sv
